[design/hmht_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmht_pkg: shared types and constants of the heat max-merge hash table
// Holds the action and status codes, the hash constants and the command
// and status structs that pass between controller and datapath.
// ----------------------------------------------------------------------------
package hmht_pkg;

  localparam int ACT_W  = 2;
  localparam int HEAT_W = 16;
  localparam int STAT_W = 2;

  // Action codes of an input item.
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_RSVD   = 2'd3;

  // Status codes of a result item.
  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
  localparam logic [STAT_W-1:0] STAT_ZERO = 2'd2;

  // Finaliser constants and shift amounts.
  localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;
  localparam int MIX_S1 = 30;
  localparam int MIX_S2 = 27;
  localparam int MIX_S3 = 31;

  // Load limit: an insert of a new key is refused once
  // (count + 1) * LOAD_DEN >= slots * LOAD_NUM.
  localparam int LOAD_NUM = 7;
  localparam int LOAD_DEN = 10;

  typedef enum logic [3:0] {
    ST_CLR_RST,
    ST_IDLE,
    ST_DECODE,
    ST_M1_0,
    ST_M1_1,
    ST_M1_2,
    ST_M1_3,
    ST_M2_0,
    ST_M2_1,
    ST_M2_2,
    ST_M2_3,
    ST_HASH,
    ST_PROBE_RD,
    ST_PROBE_CHK,
    ST_CLR_OP,
    ST_RESP
  } state_e;

  // Which 32x32 partial product the shared multiplier forms.
  typedef enum logic [1:0] {
    PART_LL,
    PART_HL,
    PART_LH
  } part_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_e;

  typedef enum logic [1:0] {
    V_HOLD,
    V_MIX27,
    V_PROD
  } v_op_e;

  typedef enum logic [1:0] {
    IDX_HOLD,
    IDX_HASH,
    IDX_NEXT
  } idx_op_e;

  typedef enum logic [2:0] {
    RES_HOLD,
    RES_ZERO,
    RES_ZKEY,
    RES_FULL,
    RES_HIT,
    RES_NEW
  } res_op_e;

  typedef struct packed {
    logic    req_ready;
    logic    const2;
    part_e   part;
    acc_op_e acc_op;
    v_op_e   v_op;
    idx_op_e idx_op;
    res_op_e res_op;
    logic    wr_key;
    logic    wr_heat;
    logic    cnt_inc;
    logic    cnt_clr;
    logic    clr_step;
    logic    rsp_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic             req_valid;
    logic [ACT_W-1:0] act;
    logic             key_zero;
    logic             hit;
    logic             empty;
    logic             probe_last;
    logic             full;
    logic             clr_last;
    logic             rsp_free;
  } dp_status_t;

endpackage

[design/hmht_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmht_req_if: request channel of the hash table
// Valid/ready channel carrying one action, key and heat per item.
// ----------------------------------------------------------------------------
interface hmht_req_if
  import hmht_pkg::*;
#(
  parameter int KEY_BITS = 48
) ();
  logic                valid;
  logic                ready;
  logic [ACT_W-1:0]    action;
  logic [KEY_BITS-1:0] key;
  logic [HEAT_W-1:0]   heat;

  modport source (output valid, action, key, heat, input ready);
  modport sink   (input valid, action, key, heat, output ready);
endinterface

[design/hmht_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmht_rsp_if: response channel of the hash table
// Valid/ready channel carrying heat, found flag and status per item.
// ----------------------------------------------------------------------------
interface hmht_rsp_if
  import hmht_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [HEAT_W-1:0] heat_out;
  logic              found;
  logic [STAT_W-1:0] status;

  modport source (output valid, heat_out, found, status, input ready);
  modport sink   (input valid, heat_out, found, status, output ready);
endinterface

[design/hmht_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmht_ctrl: controller of the hash table
// Sequences the clearing sweep, the two multiply rounds of the hash, the
// linear probe and the hand-over of the result to the output register.
// ----------------------------------------------------------------------------
module hmht_ctrl
  import hmht_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR_RST;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLR_RST: begin
        if (status_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (status_i.req_valid) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (status_i.act) inside
          ACT_CLEAR: state_d = ST_CLR_OP;
          ACT_INSERT, ACT_QUERY: begin
            state_d = status_i.key_zero ? ST_RESP : ST_M1_0;
          end
          default: state_d = ST_RESP;
        endcase
      end
      ST_M1_0: state_d = ST_M1_1;
      ST_M1_1: state_d = ST_M1_2;
      ST_M1_2: state_d = ST_M1_3;
      ST_M1_3: state_d = ST_M2_0;
      ST_M2_0: state_d = ST_M2_1;
      ST_M2_1: state_d = ST_M2_2;
      ST_M2_2: state_d = ST_M2_3;
      ST_M2_3: state_d = ST_HASH;
      ST_HASH: state_d = ST_PROBE_RD;
      ST_PROBE_RD: state_d = ST_PROBE_CHK;
      ST_PROBE_CHK: begin
        if (status_i.hit || status_i.empty || status_i.probe_last) begin
          state_d = ST_RESP;
        end else begin
          state_d = ST_PROBE_RD;
        end
      end
      ST_CLR_OP: begin
        if (status_i.clr_last) state_d = ST_RESP;
      end
      ST_RESP: begin
        if (status_i.rsp_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLR_RST;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.part   = PART_LL;
    cmd_o.acc_op = ACC_HOLD;
    cmd_o.v_op   = V_HOLD;
    cmd_o.idx_op = IDX_HOLD;
    cmd_o.res_op = RES_HOLD;
    unique case (state_q)
      ST_CLR_RST, ST_CLR_OP: begin
        cmd_o.clr_step = 1'b1;
        cmd_o.cnt_clr  = 1'b1;
        if (state_q == ST_CLR_OP && status_i.clr_last) cmd_o.res_op = RES_ZERO;
      end
      ST_IDLE: begin
        cmd_o.req_ready = 1'b1;
      end
      ST_DECODE: begin
        unique case (status_i.act) inside
          ACT_CLEAR: cmd_o.res_op = RES_HOLD;
          ACT_INSERT, ACT_QUERY: begin
            if (status_i.key_zero) cmd_o.res_op = RES_ZKEY;
          end
          default: cmd_o.res_op = RES_ZERO;
        endcase
      end
      ST_M1_0, ST_M2_0: begin
        cmd_o.const2 = (state_q == ST_M2_0);
        cmd_o.part   = PART_LL;
      end
      ST_M1_1, ST_M2_1: begin
        cmd_o.const2 = (state_q == ST_M2_1);
        cmd_o.part   = PART_HL;
        cmd_o.acc_op = ACC_LOAD;
      end
      ST_M1_2, ST_M2_2: begin
        cmd_o.const2 = (state_q == ST_M2_2);
        cmd_o.part   = PART_LH;
        cmd_o.acc_op = ACC_ADD;
      end
      ST_M1_3: begin
        cmd_o.v_op = V_MIX27;
      end
      ST_M2_3: begin
        cmd_o.v_op = V_PROD;
      end
      ST_HASH: begin
        cmd_o.idx_op = IDX_HASH;
      end
      ST_PROBE_RD: begin
        cmd_o.idx_op = IDX_HOLD;
      end
      ST_PROBE_CHK: begin
        if (status_i.hit) begin
          cmd_o.res_op  = RES_HIT;
          cmd_o.wr_heat = (status_i.act == ACT_INSERT);
        end else if (status_i.empty) begin
          if (status_i.act != ACT_INSERT) begin
            cmd_o.res_op = RES_ZERO;
          end else if (status_i.full) begin
            cmd_o.res_op = RES_FULL;
          end else begin
            cmd_o.res_op  = RES_NEW;
            cmd_o.wr_key  = 1'b1;
            cmd_o.wr_heat = 1'b1;
            cmd_o.cnt_inc = 1'b1;
          end
        end else if (status_i.probe_last) begin
          // Every slot holds another key: absent for a query, full for an insert.
          cmd_o.res_op = (status_i.act == ACT_INSERT) ? RES_FULL : RES_ZERO;
        end else begin
          cmd_o.idx_op = IDX_NEXT;
        end
      end
      ST_RESP: begin
        cmd_o.rsp_load = status_i.rsp_free;
      end
      default: cmd_o.res_op = RES_HOLD;
    endcase
  end

endmodule

[design/hmht_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmht_dp: datapath of the hash table
// Request capture, shared 32x32 multiplier for the hash, slot memories,
// probe pointer, entry count, clearing sweep and the output register.
// ----------------------------------------------------------------------------
module hmht_dp
  import hmht_pkg::*;
#(
  parameter int SLOTS    = 1024,
  parameter int KEY_BITS = 48
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  input  logic [ACT_W-1:0]    req_action_i,
  input  logic [KEY_BITS-1:0] req_key_i,
  input  logic [HEAT_W-1:0]   req_heat_i,
  input  logic                rsp_ready_i,
  input  ctrl_cmd_t           cmd_i,
  output dp_status_t          status_o,
  output logic                rsp_valid_o,
  output logic [HEAT_W-1:0]   rsp_heat_out_o,
  output logic                rsp_found_o,
  output logic [STAT_W-1:0]   rsp_status_o
);

  localparam int IDX_W  = $clog2(SLOTS);
  localparam int CNT_W  = IDX_W + 1;
  localparam int LOAD_W = CNT_W + 4;
  localparam logic [LOAD_W-1:0] LOAD_LIMIT = LOAD_W'(SLOTS * LOAD_NUM);

  // Captured request.
  logic [ACT_W-1:0]    act_q;
  logic [KEY_BITS-1:0] key_q;
  logic [HEAT_W-1:0]   heat_q;

  // Hash datapath.
  logic [63:0] v_q, acc_q, prod_q;
  logic [63:0] mix_c, mul_p, sum, key_x, hash_v;
  logic [31:0] mul_a, mul_b;

  // Probe and memories.
  logic [IDX_W-1:0]    idx_q, steps_q, clr_idx_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [KEY_BITS-1:0] mem_key [SLOTS];
  logic [HEAT_W-1:0]   mem_heat [SLOTS];
  logic [KEY_BITS-1:0] rd_key_q;
  logic [HEAT_W-1:0]   rd_heat_q;
  logic                key_we;
  logic [IDX_W-1:0]    key_wa;
  logic [KEY_BITS-1:0] key_wd;
  logic [HEAT_W-1:0]   merged, heat_wd;
  logic [LOAD_W-1:0]   load_next;

  // Result staging and output register.
  logic [HEAT_W-1:0] res_heat_q, rsp_heat_q;
  logic              res_found_q, rsp_found_q;
  logic [STAT_W-1:0] res_status_q, rsp_status_q;
  logic              rsp_valid_q;

  assign key_x = 64'(req_key_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.req_ready && req_valid_i) begin
      act_q  <= req_action_i;
      key_q  <= req_key_i;
      heat_q <= req_heat_i;
    end
  end

  // Shared multiplier: each 64-bit product is built from three partial
  // products, low half of the result only.
  assign mix_c = cmd_i.const2 ? MIX_C2 : MIX_C1;

  always_comb begin
    case (cmd_i.part)
      PART_HL: begin
        mul_a = v_q[63:32];
        mul_b = mix_c[31:0];
      end
      PART_LH: begin
        mul_a = v_q[31:0];
        mul_b = mix_c[63:32];
      end
      default: begin
        mul_a = v_q[31:0];
        mul_b = mix_c[31:0];
      end
    endcase
  end

  assign mul_p  = 64'(mul_a) * 64'(mul_b);
  assign sum    = acc_q + {prod_q[31:0], 32'h0};
  assign hash_v = v_q ^ (v_q >> MIX_S3);

  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    case (cmd_i.acc_op)
      ACC_LOAD: acc_q <= prod_q;
      ACC_ADD:  acc_q <= sum;
      default:  acc_q <= acc_q;
    endcase
    if (cmd_i.req_ready && req_valid_i) begin
      v_q <= key_x ^ (key_x >> MIX_S1);
    end else begin
      case (cmd_i.v_op)
        V_MIX27: v_q <= sum ^ (sum >> MIX_S2);
        V_PROD:  v_q <= sum;
        default: v_q <= v_q;
      endcase
    end
    case (cmd_i.idx_op)
      IDX_HASH: begin
        idx_q   <= hash_v[IDX_W-1:0];
        steps_q <= '0;
      end
      IDX_NEXT: begin
        idx_q   <= idx_q + IDX_W'(1);
        steps_q <= steps_q + IDX_W'(1);
      end
      default: begin
        idx_q   <= idx_q;
        steps_q <= steps_q;
      end
    endcase
  end

  // Slot memories: one write port, one registered read port at the probe pointer.
  assign key_we  = cmd_i.clr_step || cmd_i.wr_key;
  assign key_wa  = cmd_i.clr_step ? clr_idx_q : idx_q;
  assign key_wd  = cmd_i.clr_step ? '0 : key_q;
  assign merged  = (act_q == ACT_INSERT && heat_q > rd_heat_q) ? heat_q : rd_heat_q;
  assign heat_wd = cmd_i.wr_key ? heat_q : merged;

  always_ff @(posedge clk_i) begin
    if (key_we) mem_key[key_wa] <= key_wd;
    rd_key_q <= mem_key[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_heat) mem_heat[idx_q] <= heat_wd;
    rd_heat_q <= mem_heat[idx_q];
  end

  assign load_next = (LOAD_W'(cnt_q) + LOAD_W'(1)) * LOAD_W'(LOAD_DEN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      clr_idx_q <= '0;
    end else begin
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (cmd_i.clr_step) clr_idx_q <= clr_idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.res_op)
      RES_ZERO: begin
        res_heat_q   <= '0;
        res_found_q  <= 1'b0;
        res_status_q <= STAT_OK;
      end
      RES_ZKEY: begin
        res_heat_q   <= '0;
        res_found_q  <= 1'b0;
        res_status_q <= STAT_ZERO;
      end
      RES_FULL: begin
        res_heat_q   <= '0;
        res_found_q  <= 1'b0;
        res_status_q <= STAT_FULL;
      end
      RES_HIT: begin
        res_heat_q   <= merged;
        res_found_q  <= 1'b1;
        res_status_q <= STAT_OK;
      end
      RES_NEW: begin
        res_heat_q   <= heat_q;
        res_found_q  <= 1'b0;
        res_status_q <= STAT_OK;
      end
      default: begin
        res_heat_q   <= res_heat_q;
        res_found_q  <= res_found_q;
        res_status_q <= res_status_q;
      end
    endcase
  end

  // Output register: a finished item waits here while the next is accepted.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_i.rsp_load) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rsp_load) begin
      rsp_heat_q   <= res_heat_q;
      rsp_found_q  <= res_found_q;
      rsp_status_q <= res_status_q;
    end
  end

  assign rsp_valid_o    = rsp_valid_q;
  assign rsp_heat_out_o = rsp_heat_q;
  assign rsp_found_o    = rsp_found_q;
  assign rsp_status_o   = rsp_status_q;

  assign status_o.req_valid  = req_valid_i;
  assign status_o.act        = act_q;
  assign status_o.key_zero   = (key_q == '0);
  assign status_o.hit        = (rd_key_q == key_q);
  assign status_o.empty      = (rd_key_q == '0);
  assign status_o.probe_last = &steps_q;
  assign status_o.full       = (load_next >= LOAD_LIMIT);
  assign status_o.clr_last   = &clr_idx_q;
  assign status_o.rsp_free   = !rsp_valid_q || rsp_ready_i;

endmodule

[design/heat_max_merge_hash_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heat_max_merge_hash_table: block address to heat hash table
// Open-addressing table with splitmix64 home slots and linear probing.
// Insert max-merges a heat, query looks it up, clear empties the table.
//
// Usage: items arrive on req_i (action, key, heat) and one result per item
// leaves on rsp_o (heat_out, found, status); both are valid/ready channels.
// One item is worked on at a time. An insert or query with a nonzero key
// is hashed and probed from its home slot until a slot decides it or all
// slots are probed: the hash runs two 64-bit multiplies through one shared
// 32x32 multiplier, and each probe is one registered read of the key
// memory. A zero key or an undefined action answers without hashing, a
// clear sweeps the key memory with one key memory write per cycle.
// req_i.ready rises again with the result, so a new item is accepted
// only after the last one is finished. After reset the block sweeps the
// key memory before req_i.ready first rises. A finished result waits in
// the output register
// while the next item is accepted; with the receiver stalled, the block
// holds the following result until the register is free.
// ----------------------------------------------------------------------------
module heat_max_merge_hash_table
  import hmht_pkg::*;
#(
  parameter int SLOTS    = 1024,
  parameter int KEY_BITS = 48
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hmht_req_if.sink   req_i,
  hmht_rsp_if.source rsp_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign req_i.ready = cmd.req_ready;

  hmht_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  hmht_dp #(
    .SLOTS    (SLOTS),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (req_i.valid),
    .req_action_i   (req_i.action),
    .req_key_i      (req_i.key),
    .req_heat_i     (req_i.heat),
    .rsp_ready_i    (rsp_o.ready),
    .cmd_i          (cmd),
    .status_o       (status),
    .rsp_valid_o    (rsp_o.valid),
    .rsp_heat_out_o (rsp_o.heat_out),
    .rsp_found_o    (rsp_o.found),
    .rsp_status_o   (rsp_o.status)
  );

endmodule

[design/hmht_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmht_checker: port-level checks of the hash table
// Watches the request and response channels and is bound to the top level.
// ----------------------------------------------------------------------------
module hmht_checker
  import hmht_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              req_valid_i,
  input logic              req_ready_i,
  input logic              rsp_valid_i,
  input logic              rsp_ready_i,
  input logic [HEAT_W-1:0] rsp_heat_out_i,
  input logic              rsp_found_i,
  input logic [STAT_W-1:0] rsp_status_i
);

  // Only one item is in work, so ready drops right after an acceptance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) |=> !req_ready_i)
    else $error("request accepted while another item is in work");

  // No result can be produced in the cycle that follows an acceptance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) |=> !$rose(rsp_valid_i))
    else $error("result appeared straight after acceptance");

  // A rejected or failed request carries no heat and no found flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && (rsp_status_i != STAT_OK)) |-> (rsp_heat_out_i == '0 && !rsp_found_i))
    else $error("rejected item carries data");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=>
      (rsp_valid_i && $stable(rsp_heat_out_i) && $stable(rsp_found_i)
       && $stable(rsp_status_i)))
    else $error("stalled result changed");

endmodule

bind heat_max_merge_hash_table hmht_checker u_hmht_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .rsp_heat_out_i (rsp_o.heat_out),
  .rsp_found_i    (rsp_o.found),
  .rsp_status_i   (rsp_o.status)
);

[test/heat_max_merge_hash_table_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heat_max_merge_hash_table_checker: result checker for the heat hash table
// Watches both channels. Every item accepted on the request channel is run
// through a local model of the table, and the result that it must give is
// queued. Every item accepted on the response channel is compared field by
// field with the oldest queued result.
// ----------------------------------------------------------------------------
module heat_max_merge_hash_table_checker
  import hmht_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  hmht_req_if  req_i,
  hmht_rsp_if  rsp_i,
  output int   fail_count_o,
  output int   pending_o
);

  localparam int TBL_SLOTS = 1024;

  typedef struct packed {
    logic [HEAT_W-1:0] heat;
    logic              found;
    logic [STAT_W-1:0] status;
  } heat_result_t;

  logic [47:0]       tbl_key  [TBL_SLOTS];
  logic [HEAT_W-1:0] tbl_heat [TBL_SLOTS];
  int                tbl_count;
  heat_result_t      heat_expect_q[$];

  // Home slot: the splitmix64 finaliser of the zero-extended key.
  function automatic logic [9:0] home_slot(input logic [47:0] key);
    logic [63:0] v;
    v = {16'd0, key};
    v = v ^ (v >> 30);
    v = v * 64'hbf58476d1ce4e5b9;
    v = v ^ (v >> 27);
    v = v * 64'h94d049bb133111eb;
    v = v ^ (v >> 31);
    return v[9:0];
  endfunction

  task automatic table_apply(input logic [ACT_W-1:0] act, input logic [47:0] key,
                             input logic [HEAT_W-1:0] heat, output heat_result_t res);
    logic [9:0] idx;
    bit         hit;
    bit         stop;
    int         steps;
    res  = '0;
    hit  = 1'b0;
    stop = 1'b0;
    case (act)
      ACT_CLEAR: begin
        for (int s = 0; s < TBL_SLOTS; s++) tbl_key[s] = '0;
        tbl_count = 0;
      end
      ACT_INSERT, ACT_QUERY: begin
        if (key == '0) begin
          res.status = STAT_ZERO;
        end else begin
          idx = home_slot(key);
          for (steps = 0; steps < TBL_SLOTS && !stop; steps++) begin
            if (tbl_key[idx] == key) begin
              hit  = 1'b1;
              stop = 1'b1;
            end else if (tbl_key[idx] == '0) begin
              stop = 1'b1;
            end else begin
              idx = idx + 10'd1;
            end
          end
          if (!stop) begin
            if (act == ACT_INSERT) res.status = STAT_FULL;
          end else if (act == ACT_QUERY) begin
            if (hit) begin
              res.heat  = tbl_heat[idx];
              res.found = 1'b1;
            end
          end else if (hit) begin
            if (heat > tbl_heat[idx]) tbl_heat[idx] = heat;
            res.heat  = tbl_heat[idx];
            res.found = 1'b1;
          end else if ((tbl_count + 1) * 10 >= TBL_SLOTS * 7) begin
            // A new key would push the load to 70 per cent or beyond.
            res.status = STAT_FULL;
          end else begin
            tbl_key[idx]  = key;
            tbl_heat[idx] = heat;
            tbl_count++;
            res.heat = heat;
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    heat_result_t want;
    heat_result_t seen;
    if (!rst_ni) begin
      for (int s = 0; s < TBL_SLOTS; s++) begin
        tbl_key[s]  = '0;
        tbl_heat[s] = '0;
      end
      tbl_count = 0;
      heat_expect_q.delete();
      fail_count_o = 0;
    end else begin
      if (req_i.valid && req_i.ready) begin
        table_apply(req_i.action, req_i.key, req_i.heat, want);
        heat_expect_q.push_back(want);
      end
      if (rsp_i.valid && rsp_i.ready) begin
        seen = '{heat: rsp_i.heat_out, found: rsp_i.found, status: rsp_i.status};
        if (heat_expect_q.size() == 0) begin
          $error("result item with none outstanding: heat_out %0h found %0b status %0d",
                 seen.heat, seen.found, seen.status);
          fail_count_o++;
        end else begin
          want = heat_expect_q.pop_front();
          if (seen.heat !== want.heat) begin
            $error("heat_out: expected %0h, actual %0h", want.heat, seen.heat);
            fail_count_o++;
          end
          if (seen.found !== want.found) begin
            $error("found: expected %0b, actual %0b", want.found, seen.found);
            fail_count_o++;
          end
          if (seen.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, seen.status);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = heat_expect_q.size();
  end

endmodule

[test/heat_max_merge_hash_table_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heat_max_merge_hash_table_tb: testbench of the heat hash table
// A directed opening covers zero keys, the reserved action, clears and the
// heat extremes. Random traffic then mixes inserts and queries over a small
// pool of keys, fills the table to its load limit so that new keys are
// refused, and works the full table. Both sides idle at random; the
// receiver also stalls for a long stretch. A separate checker judges the
// results.
// ----------------------------------------------------------------------------
module heat_max_merge_hash_table_tb;
  import hmht_pkg::*;

  localparam int CLK_HALF    = 6;
  localparam int CYCLE_LIMIT = 1_000_000;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   items_sent;
  logic [47:0] key_pool[$];

  hmht_req_if #(.KEY_BITS(48)) req_if ();
  hmht_rsp_if                  rsp_if ();

  heat_max_merge_hash_table #(
    .SLOTS   (1024),
    .KEY_BITS(48)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  heat_max_merge_hash_table_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_i       (rsp_if),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Neither side idles while this window of items goes through.
  wire calm = (items_sent >= 700) && (items_sent < 1000);

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off that backs the table up.
  initial begin : receiver
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!hold_done && items_sent >= 300) begin
        hold_left = 700;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        rsp_if.ready = 1'b0;
        hold_left--;
      end else if (calm) begin
        rsp_if.ready = 1'b1;
      end else begin
        rsp_if.ready = ($urandom_range(99) >= 9);
      end
    end
  end

  function automatic logic [47:0] fresh_key();
    logic [47:0] k;
    k = '0;
    while (k == '0) k = {16'($urandom_range(16'hFFFF, 0)), $urandom};
    return k;
  endfunction

  function automatic logic [47:0] pool_key();
    if (key_pool.size() == 0) return fresh_key();
    return key_pool[$urandom_range(key_pool.size() - 1)];
  endfunction

  task automatic send_item(input logic [ACT_W-1:0] act, input logic [47:0] key,
                           input logic [HEAT_W-1:0] heat);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 9) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.valid  = 1'b1;
    req_if.action = act;
    req_if.key    = key;
    req_if.heat   = heat;
    do @(posedge clk_i); while (!req_if.ready);
    items_sent++;
    if (act == ACT_CLEAR) key_pool.delete();
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Mixed traffic over the pool of inserted keys, with zero keys, reserved actions and the odd clear.
  task automatic send_mixed();
    int          r;
    logic [47:0] k;
    r = $urandom_range(99);
    if (r < 40) begin
      if ($urandom_range(1)) begin
        k = fresh_key();
        key_pool.push_back(k);
      end else begin
        k = pool_key();
      end
      send_item(ACT_INSERT, k, HEAT_W'($urandom));
    end else if (r < 75) begin
      k = ($urandom_range(9) < 6) ? pool_key() : fresh_key();
      send_item(ACT_QUERY, k, HEAT_W'($urandom));
    end else if (r < 82) begin
      send_item($urandom_range(1) ? ACT_INSERT : ACT_QUERY, '0, HEAT_W'($urandom));
    end else if (r < 98) begin
      send_item(ACT_RSVD, $urandom_range(3) == 0 ? 48'd0 : fresh_key(), HEAT_W'($urandom));
    end else if (r < 99) begin
      send_item(ACT_QUERY, pool_key(), HEAT_W'($urandom));
    end else begin
      send_item(ACT_CLEAR, fresh_key(), HEAT_W'($urandom));
    end
  endtask

  initial begin : sender
    int          r;
    logic [47:0] k;
    rst_ni        = 1'b0;
    items_sent    = 0;
    req_if.valid  = 1'b0;
    req_if.action = ACT_INSERT;
    req_if.key    = '0;
    req_if.heat   = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed opening.
    send_item(ACT_QUERY,  48'd1, 16'h0000);
    send_item(ACT_INSERT, 48'd0, 16'h0005);
    send_item(ACT_QUERY,  48'd0, 16'hFFFF);
    send_item(ACT_RSVD,   48'h1234_5678_9ABC, 16'h00FF);
    send_item(ACT_INSERT, 48'd1, 16'h0000);
    send_item(ACT_INSERT, 48'd1, 16'h0064);
    send_item(ACT_INSERT, 48'd1, 16'h0032);
    send_item(ACT_QUERY,  48'd1, 16'h0000);
    send_item(ACT_INSERT, 48'hFFFF_FFFF_FFFF, 16'hFFFF);
    send_item(ACT_INSERT, 48'hFFFF_FFFF_FFFF, 16'h0000);
    send_item(ACT_QUERY,  48'hFFFF_FFFF_FFFF, 16'h0000);
    send_item(ACT_INSERT, 48'h8000_0000_0000, 16'h8000);
    send_item(ACT_INSERT, 48'h5555_5555_5555, 16'h5555);
    send_item(ACT_INSERT, 48'hAAAA_AAAA_AAAA, 16'hAAAA);
    send_item(ACT_QUERY,  48'h8000_0000_0000, 16'h0000);
    send_item(ACT_CLEAR,  48'hFFFF_FFFF_FFFF, 16'hFFFF);
    send_item(ACT_QUERY,  48'd1, 16'h0000);
    send_item(ACT_INSERT, 48'd1, 16'h0007);
    send_item(ACT_RSVD,   48'd0, 16'h0000);
    send_item(ACT_CLEAR,  48'd0, 16'h0000);

    for (int i = 0; i < 500; i++) send_mixed();

    // Let everything out before refilling from empty.
    wait_drained();
    send_item(ACT_CLEAR, fresh_key(), HEAT_W'($urandom));

    // Fill past the load limit: new keys beyond it are refused.
    for (int i = 0; i < 860; i++) begin
      r = $urandom_range(99);
      if (r < 92) begin
        k = fresh_key();
        key_pool.push_back(k);
        send_item(ACT_INSERT, k, HEAT_W'($urandom));
      end else if (r < 97) begin
        send_item(ACT_QUERY, pool_key(), HEAT_W'($urandom));
      end else begin
        send_item(ACT_INSERT, pool_key(), HEAT_W'($urandom));
      end
    end

    // Full table: merges still go through, new keys do not.
    for (int i = 0; i < 130; i++) begin
      r = $urandom_range(99);
      if (r < 35) send_item(ACT_INSERT, pool_key(), HEAT_W'($urandom));
      else if (r < 55) send_item(ACT_INSERT, fresh_key(), HEAT_W'($urandom));
      else if (r < 85) send_item(ACT_QUERY, pool_key(), HEAT_W'($urandom));
      else if (r < 92) send_item(ACT_QUERY, fresh_key(), HEAT_W'($urandom));
      else if (r < 96) send_item(ACT_INSERT, '0, HEAT_W'($urandom));
      else send_item(ACT_RSVD, fresh_key(), HEAT_W'($urandom));
    end

    send_item(ACT_CLEAR, fresh_key(), HEAT_W'($urandom));
    for (int i = 0; i < 40; i++) send_mixed();

    wait_drained();
    repeat (30) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
design/hmht_pkg.sv
design/hmht_req_if.sv
design/hmht_rsp_if.sv
design/hmht_ctrl.sv
design/hmht_dp.sv
design/heat_max_merge_hash_table.sv
design/hmht_checker.sv
test/heat_max_merge_hash_table_checker.sv
test/heat_max_merge_hash_table_tb.sv
